### sv/stbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table bound search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  localparam kind_t KIND_LOWER = 2'd0;
  localparam kind_t KIND_UPPER = 2'd1;
  localparam kind_t KIND_FLOOR = 2'd2;
  localparam kind_t KIND_CEIL  = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_ORDER     = 2'd3;

endpackage

### sv/sorted_table_bound_search.sv
`timescale 1ns / 1ps
// Clear, append and unused commands: result strobe in the cycle after accept; busy stays low.
// Query on a non-empty table: busy while searching, one table probe per cycle
// through the RAM's registered read port; result strobe in the cycle after the last probe.
// Empty-table queries are answered like the other commands, without a search.
// Reset clears the entry count and last entry; table contents are not cleared.
// Results cannot be stalled: each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// sorted_table_bound_search
// Sorted table with append/clear and lower, upper, floor and ceil queries.
// ----------------------------------------------------------------------------
module sorted_table_bound_search import stbs_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  cmd_t                          in_command,
  input  kind_t                         in_query_kind,
  input  logic [VALUE_WIDTH-1:0]        in_item_value,
  output logic                          out_valid,
  output logic [$clog2(DEPTH+1)-1:0]    out_result_index,
  output status_t                       out_status
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] last_r, last_nxt;
  kind_t                  kind_r, kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]       out_index_r, out_index_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   accept;
  logic                   srch_start;
  logic                   srch_strict;
  logic                   srch_done;
  logic [CNT_W-1:0]       srch_pos;
  logic [ADDR_W-1:0]      rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;

  logic [CNT_W-1:0] res_pos;
  kind_t            res_kind;
  logic [CNT_W-1:0] res_index;
  status_t          res_status;

  assign accept      = start && !busy;
  assign busy        = (state_r == S_SEARCH);
  assign srch_strict = (in_query_kind == KIND_UPPER) || (in_query_kind == KIND_FLOOR);
  assign srch_start  = accept && (in_command == CMD_QUERY) && (count_r != '0);

  // map the search position to the answer of each query kind
  always_comb begin
    res_pos    = (state_r == S_SEARCH) ? srch_pos : '0;
    res_kind   = (state_r == S_SEARCH) ? kind_r : in_query_kind;
    res_index  = '0;
    res_status = ST_OK;
    case (res_kind)
      KIND_LOWER, KIND_UPPER: begin
        res_index = res_pos;
      end
      KIND_FLOOR: begin
        if (res_pos == '0) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_index = res_pos - CNT_W'(1);
        end
      end
      KIND_CEIL: begin
        if (res_pos == count_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_index = res_pos;
        end
      end
      default: begin
        res_index = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    kind_nxt       = kind_r;
    out_valid_nxt  = 1'b0;
    out_index_nxt  = '0;
    out_status_nxt = ST_OK;
    wr_en          = 1'b0;
    if (state_r == S_IDLE) begin
      if (accept) begin
        out_valid_nxt = 1'b1;
        case (in_command)
          CMD_CLEAR: begin
            count_nxt = '0;
            last_nxt  = '0;
          end
          CMD_APPEND: begin
            if (count_r >= CNT_W'(DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else if ((count_r != '0) &&
                         ($signed(in_item_value) < $signed(last_r))) begin
              out_status_nxt = ST_ORDER;
            end else begin
              wr_en     = 1'b1;
              last_nxt  = in_item_value;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_QUERY: begin
            kind_nxt = in_query_kind;
            if (count_r == '0) begin
              out_index_nxt  = res_index;
              out_status_nxt = res_status;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SEARCH;
            end
          end
          default: begin
            out_status_nxt = ST_OK;
          end
        endcase
      end
    end else if (srch_done) begin
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_index_nxt  = res_index;
      out_status_nxt = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_status       = out_status_r;

  stbs_ram #(
    .WIDTH  (VALUE_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (in_item_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_search #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .strict  (srch_strict),
    .key     (in_item_value),
    .count   (count_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (srch_done),
    .pos     (srch_pos)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command != CMD_QUERY)) |=> out_valid && !busy)
    else $error("missing result after non-query item");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOT_FOUND)) |-> (out_result_index == '0))
    else $error("not-found result carries an index");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (count_r == CNT_W'(DEPTH)))
    else $error("table-full reported while table has room");

endmodule

### sv/stbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/stbs_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_search
// Binary search sequencer: one table probe and one compare per cycle,
// returns the first position whose entry is above (or at) the key.
// ----------------------------------------------------------------------------
module stbs_search #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 11,
  parameter int ADDR_W      = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   strict,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]       count,
  output logic [ADDR_W-1:0]      rd_addr,
  input  logic [VALUE_WIDTH-1:0] rd_data,
  output logic                   done,
  output logic [CNT_W-1:0]       pos
);

  logic                   active_r, active_nxt;
  logic [CNT_W-1:0]       lo_r, hi_r, mid_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic                   strict_r;

  logic             hit;
  logic             more;
  logic [CNT_W-1:0] lo_step, hi_step, mid_step;
  logic [CNT_W:0]   sum;

  always_comb begin
    hit = strict_r ? ($signed(rd_data) > $signed(key_r))
                   : ($signed(rd_data) >= $signed(key_r));
    if (active_r) begin
      lo_step = hit ? lo_r : mid_r + CNT_W'(1);
      hi_step = hit ? mid_r : hi_r;
    end else begin
      lo_step = '0;
      hi_step = count;
    end
    sum        = {1'b0, lo_step} + {1'b0, hi_step};
    mid_step   = sum[CNT_W:1];
    more       = lo_step < hi_step;
    done       = active_r && !more;
    pos        = lo_step;
    rd_addr    = mid_step[ADDR_W-1:0];
    active_nxt = start || (active_r && more);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_step;
    hi_r  <= hi_step;
    mid_r <= mid_step;
    if (start) begin
      key_r    <= key;
      strict_r <= strict;
    end
  end

  a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> lo_r < hi_r)
    else $error("search window empty while probing");

  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (mid_r >= lo_r) && (mid_r < hi_r))
    else $error("probe index outside search window");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !start) |=> !active_r)
    else $error("search still active after done");

endmodule
